>>> hw/rtl/ipru_pkg.sv
// ----------------------------------------------------------------------------
// ipru_pkg
// Types and constants shared by the pixel replication upscaler.
// ----------------------------------------------------------------------------
package ipru_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int PIX_W         = 24;
   localparam int FACTOR_W      = 7;
   localparam int SRC_WIDTH_W   = 11;
   localparam int SRC_HEIGHT_W  = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [FACTOR_W-1:0] FACTOR_LIMIT = 7'd100;

   // output queue, power of two deep
   localparam int QDEPTH    = 4;
   localparam int Q_PTR_W   = $clog2(QDEPTH);
   localparam int Q_CNT_W   = $clog2(QDEPTH + 1);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_LOAD_BUSY = 2'd1,
      STAT_NO_ROW    = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_FACTOR  = 2'd0,
      CSR_SOURCE_WIDTH  = 2'd1,
      CSR_SOURCE_HEIGHT = 2'd2
   } csr_index_type;

   // everything about a result except the pixel itself
   typedef struct packed {
      logic       use_pixel;
      logic [1:0] pad_bytes;
      logic       row_end;
      logic       image_end;
      status_type status;
   } rsp_info_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic [1:0]       pad_bytes;
      logic             row_end;
      logic             image_end;
      status_type       status;
   } result_type;

endpackage

>>> hw/rtl/ipru_req_if.sv
// ----------------------------------------------------------------------------
// ipru_req_if
// Request channel: load or emit items with a source pixel.
// ----------------------------------------------------------------------------
interface ipru_req_if import ipru_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

>>> hw/rtl/ipru_rsp_if.sv
// ----------------------------------------------------------------------------
// ipru_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface ipru_rsp_if import ipru_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic [1:0]       pad_bytes;
   logic             row_end;
   logic             image_end;
   logic [1:0]       status;

   modport source (output valid, output pixel_out, output pad_bytes, output row_end,
                   output image_end, output status, input ready);
   modport sink   (input valid, input pixel_out, input pad_bytes, input row_end,
                   input image_end, input status, output ready);
endinterface

>>> hw/rtl/ipru_lbuf.sv
// ----------------------------------------------------------------------------
// ipru_lbuf
// Line buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ipru_lbuf import ipru_pkg::*; #(
   parameter int DEPTH  = MAX_WIDTH_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PIX_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] line_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ipru_ctrl.sv
// ----------------------------------------------------------------------------
// ipru_ctrl
// Control registers, load/read counters and result decode.
// ----------------------------------------------------------------------------
module ipru_ctrl import ipru_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   parameter int W_W       = $clog2(MAX_WIDTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    acc,
   input  logic                    opcode,
   output logic                    wr_en,
   output logic [COL_W-1:0]        wr_addr,
   output logic                    rd_en,
   output logic [COL_W-1:0]        rd_addr,
   output rsp_info_type            info
);

   logic [FACTOR_W-1:0]     factor_ff;
   logic [SRC_WIDTH_W-1:0]  src_width_ff;
   logic [SRC_HEIGHT_W-1:0] src_height_ff;

   logic [COL_W-1:0]        load_col_ff, load_col_in;
   logic                    row_ready_ff, row_ready_in;
   logic [COL_W-1:0]        read_col_ff, read_col_in;
   logic [FACTOR_W-1:0]     pix_rep_ff, pix_rep_in;
   logic [FACTOR_W-1:0]     row_rep_ff, row_rep_in;
   logic [SRC_HEIGHT_W-1:0] src_row_ff, src_row_in;

   logic [FACTOR_W-1:0]     eff_f;
   logic [W_W-1:0]          eff_w;
   logic [SRC_HEIGHT_W-1:0] eff_h;
   logic [W_W-1:0]          load_next;
   logic [W_W-1:0]          read_next;
   logic [FACTOR_W:0]       pix_rep_next;
   logic [FACTOR_W:0]       row_rep_next;
   logic [SRC_HEIGHT_W:0]   src_row_next;
   logic [1:0]              w_lo;
   logic [1:0]              f_lo;
   logic                    is_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff     <= FACTOR_W'(1);
         src_width_ff  <= SRC_WIDTH_W'(1);
         src_height_ff <= SRC_HEIGHT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE_FACTOR:  factor_ff     <= csr_wdata[FACTOR_W-1:0];
            CSR_SOURCE_WIDTH:  src_width_ff  <= csr_wdata[SRC_WIDTH_W-1:0];
            CSR_SOURCE_HEIGHT: src_height_ff <= csr_wdata[SRC_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the registers into their usable ranges
   always_comb begin
      if (factor_ff == '0) begin
         eff_f = FACTOR_W'(1);
      end else if (factor_ff > FACTOR_LIMIT) begin
         eff_f = FACTOR_LIMIT;
      end else begin
         eff_f = factor_ff;
      end

      if (src_width_ff == '0) begin
         eff_w = W_W'(1);
      end else if (32'(src_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = W_W'(MAX_WIDTH);
      end else begin
         eff_w = W_W'(src_width_ff);
      end

      eff_h = (src_height_ff == '0) ? SRC_HEIGHT_W'(1) : src_height_ff;
   end

   assign load_next    = W_W'(load_col_ff) + W_W'(1);
   assign read_next    = W_W'(read_col_ff) + W_W'(1);
   assign pix_rep_next = {1'b0, pix_rep_ff} + (FACTOR_W+1)'(1);
   assign row_rep_next = {1'b0, row_rep_ff} + (FACTOR_W+1)'(1);
   assign src_row_next = {1'b0, src_row_ff} + (SRC_HEIGHT_W+1)'(1);
   assign w_lo         = 2'(eff_w);
   assign f_lo         = eff_f[1:0];
   assign is_emit      = (opcode == OP_EMIT);

   assign wr_addr = load_col_ff;
   assign rd_addr = read_col_ff;

   always_comb begin
      load_col_in  = load_col_ff;
      row_ready_in = row_ready_ff;
      read_col_in  = read_col_ff;
      pix_rep_in   = pix_rep_ff;
      row_rep_in   = row_rep_ff;
      src_row_in   = src_row_ff;
      info         = '0;
      info.status  = STAT_OK;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      if (!is_emit) begin
         if (row_ready_ff) begin
            info.status = STAT_LOAD_BUSY;
         end else begin
            wr_en       = acc;
            load_col_in = COL_W'(load_next);
            if (load_next >= eff_w) begin
               load_col_in  = '0;
               row_ready_in = 1'b1;
               read_col_in  = '0;
               pix_rep_in   = '0;
               row_rep_in   = '0;
            end
         end
      end else if (!row_ready_ff) begin
         info.status = STAT_NO_ROW;
      end else begin
         rd_en          = acc;
         info.use_pixel = 1'b1;
         pix_rep_in     = pix_rep_next[FACTOR_W-1:0];
         if (pix_rep_next >= {1'b0, eff_f}) begin
            pix_rep_in  = '0;
            read_col_in = COL_W'(read_next);
            if (read_next >= eff_w) begin
               // 3 bytes per pixel, so the pad is width * factor mod 4
               read_col_in    = '0;
               info.row_end   = 1'b1;
               info.pad_bytes = 2'(w_lo * f_lo);
               row_rep_in     = row_rep_next[FACTOR_W-1:0];
               if (row_rep_next >= {1'b0, eff_f}) begin
                  row_rep_in   = '0;
                  row_ready_in = 1'b0;
                  src_row_in   = src_row_next[SRC_HEIGHT_W-1:0];
                  if (src_row_next >= {1'b0, eff_h}) begin
                     src_row_in      = '0;
                     info.image_end  = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff  <= '0;
         row_ready_ff <= 1'b0;
         read_col_ff  <= '0;
         pix_rep_ff   <= '0;
         row_rep_ff   <= '0;
         src_row_ff   <= '0;
      end else if (acc) begin
         load_col_ff  <= load_col_in;
         row_ready_ff <= row_ready_in;
         read_col_ff  <= read_col_in;
         pix_rep_ff   <= pix_rep_in;
         row_rep_ff   <= row_rep_in;
         src_row_ff   <= src_row_in;
      end
   end

`ifndef SYNTHESIS
   a_load_idle_while_ready: assert property (@(posedge clock) disable iff (reset)
      row_ready_ff |-> (load_col_ff == '0))
      else $error("load column moved while a row is held");

   a_read_idle_without_row: assert property (@(posedge clock) disable iff (reset)
      !row_ready_ff |-> (read_col_ff == '0 && pix_rep_ff == '0 && row_rep_ff == '0))
      else $error("read counters not cleared without a row");

   a_image_end_ends_row: assert property (@(posedge clock) disable iff (reset)
      (acc && info.image_end) |-> (info.row_end && !row_ready_in))
      else $error("image end without row end");
`endif

endmodule

>>> hw/rtl/ipru_outq.sv
// ----------------------------------------------------------------------------
// ipru_outq
// Read-data stage and result queue in front of the response channel.
// ----------------------------------------------------------------------------
module ipru_outq import ipru_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_acc,
   input  rsp_info_type     in_info,
   input  logic [PIX_W-1:0] rd_data,
   output logic             in_ready,
   ipru_rsp_if.source       rsp_ch
);

   logic             s1_valid_ff;
   rsp_info_type     s1_info_ff;
   result_type       q_ff [QDEPTH];
   result_type       q_entry;
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_CNT_W-1:0] q_cnt_ff;
   logic [Q_CNT_W-1:0] occ_ff;
   logic             push;
   logic             pop;

   // occupancy counts the read stage too, so a transfer in always finds room
   assign in_ready = (occ_ff < Q_CNT_W'(QDEPTH));
   assign push     = s1_valid_ff;
   assign pop      = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      q_entry.pixel_out = s1_info_ff.use_pixel ? rd_data : '0;
      q_entry.pad_bytes = s1_info_ff.pad_bytes;
      q_entry.row_end   = s1_info_ff.row_end;
      q_entry.image_end = s1_info_ff.image_end;
      q_entry.status    = s1_info_ff.status;
   end

   always_ff @(posedge clock) begin
      s1_info_ff <= in_info;
      if (push) begin
         q_ff[wr_ptr_ff] <= q_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         q_cnt_ff    <= '0;
         occ_ff      <= '0;
      end else begin
         s1_valid_ff <= in_acc;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         q_cnt_ff <= q_cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
         occ_ff   <= occ_ff + Q_CNT_W'(in_acc) - Q_CNT_W'(pop);
      end
   end

   assign rsp_ch.valid     = (q_cnt_ff != '0);
   assign rsp_ch.pixel_out = q_ff[rd_ptr_ff].pixel_out;
   assign rsp_ch.pad_bytes = q_ff[rd_ptr_ff].pad_bytes;
   assign rsp_ch.row_end   = q_ff[rd_ptr_ff].row_end;
   assign rsp_ch.image_end = q_ff[rd_ptr_ff].image_end;
   assign rsp_ch.status    = q_ff[rd_ptr_ff].status;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= Q_CNT_W'(QDEPTH))
      else $error("result queue overrun");

   a_occ_matches: assert property (@(posedge clock) disable iff (reset)
      (q_cnt_ff + Q_CNT_W'(s1_valid_ff)) == occ_ff)
      else $error("occupancy out of step with queue");
`endif

endmodule

>>> hw/rtl/integer_pixel_replication_upscaler.sv
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbor integer upscaler for rows of 24-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries items: opcode load writes pixel_in into the line buffer,
//   opcode emit reads the next output pixel. Every request gives exactly one
//   response on rsp_ch, in order, with pixel, pad bytes, row/image end flags
//   and status (load rejected while a row is held, emit with no row).
//   csr_we/csr_index/csr_wdata set scale factor, source width and height;
//   write them only while no transfer is outstanding.
//   Throughput: one transfer per cycle in steady state, while rsp_ch keeps
//   taking results. The line buffer read is registered when the request
//   transfers, and the result is then written into the result queue that
//   drives rsp_ch.
//   A 4-entry result queue sits in front of rsp_ch; req_ch.ready drops only
//   when four results are in flight, so a stalled receiver backs up into the
//   request side after four transfers and nothing is lost.
//   Synchronous reset clears counters, the held-row flag and the queue and
//   sets the scale factor, source width and height registers to 1. The line
//   buffer is not cleared; only entries loaded since reset are ever read.
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler import ipru_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ipru_req_if.sink               req_ch,
   ipru_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int W_W   = $clog2(MAX_WIDTH + 1);

   logic             acc;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   logic             rd_en;
   logic [COL_W-1:0] rd_addr;
   logic [PIX_W-1:0] rd_data;
   rsp_info_type     info;
   logic             in_ready;

   assign req_ch.ready = in_ready;
   assign acc          = req_ch.valid && in_ready;

   ipru_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W),
      .W_W       (W_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .acc       (acc),
      .opcode    (req_ch.opcode),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   ipru_lbuf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_lbuf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ipru_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .in_acc   (acc),
      .in_info  (info),
      .rd_data  (rd_data),
      .in_ready (in_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule
